// ===== rtl/fcr_pkg.sv =====
// Shared types, constants and keyword tables of the framed command recogniser.
`default_nettype none

package fcr_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_CHAR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_CHAR   = 2'd1;

    localparam logic [7:0] START_CHAR_RESET = 8'd35;
    localparam logic [7:0] END_CHAR_RESET   = 8'd37;

    // Characters with a fixed meaning.
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam int KW_COUNT = 6;
    localparam int KW_TEXT_W = 128;

    typedef logic [KW_COUNT-1:0] kw_mask_t;

    // Keyword text, right-aligned as string literals are; the first character sits highest.
    localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        KW_TEXT_W'({"SHOW_", "SCORE"}),
        KW_TEXT_W'({"SHOW_", "BYTE:"}),
        KW_TEXT_W'({"SOUND_", "TEST"}),
        KW_TEXT_W'({"DISPLAY_", "TEST"}),
        KW_TEXT_W'({"VISUAL_", "BYTE_TEST"}),
        KW_TEXT_W'({"SWITCH_", "MODE:"})
    };
    localparam logic [4:0] KW_LEN [KW_COUNT] = '{5'd10, 5'd10, 5'd10, 5'd12, 5'd16, 5'd12};
    // Keywords that end in a colon and are followed by a number.
    localparam kw_mask_t KW_PREFIX = 6'b100010;

    typedef enum logic [2:0] {
        CMD_UNKNOWN     = 3'd0,
        CMD_SCORE       = 3'd1,
        CMD_BYTE_VALUE  = 3'd2,
        CMD_TONE        = 3'd3,
        CMD_PANEL       = 3'd4,
        CMD_VISUAL_BYTE = 3'd5,
        CMD_MODE        = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        NUM_SKIP   = 2'd0,
        NUM_DIGITS = 2'd1,
        NUM_DONE   = 2'd2
    } num_phase_t;

    // One byte's effect on the message state.
    typedef struct packed {
        logic       restart;
        logic       take;
        logic [7:0] data;
    } fcr_step_t;

    // Character of keyword k at position pos; zero beyond the keyword's end.
    function automatic logic [7:0] kw_char(input int unsigned k, input logic [7:0] pos);
        logic [6:0] lsb;
        lsb = 7'd0;
        if (pos >= {3'b000, KW_LEN[k]}) begin
            return 8'h00;
        end
        lsb = ({2'b00, KW_LEN[k]} - 7'd1 - {3'b000, pos[3:0]}) << 3;
        return KW_TEXT[k][lsb +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fcr_keyword_match.sv =====
// Keyword tracking: live keyword mask, character position and final command choice.
`default_nettype none

module fcr_keyword_match (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fcr_pkg::fcr_step_t step,
    output logic                   parse_en,
    output fcr_pkg::cmd_t          command
);

    fcr_pkg::kw_mask_t alive_reg, alive_next;
    logic [7:0]        pos_reg, pos_next;
    logic [7:0]        upper;

    assign upper = (step.data >= fcr_pkg::CHAR_LOWER_A && step.data <= fcr_pkg::CHAR_LOWER_Z)
                 ? step.data - fcr_pkg::CASE_OFFSET : step.data;

    always_comb begin
        alive_next = alive_reg;
        pos_next   = pos_reg;
        parse_en   = 1'b0;
        for (int k = 0; k < fcr_pkg::KW_COUNT; k++) begin
            if (alive_reg[k]) begin
                if (pos_reg >= {3'b000, fcr_pkg::KW_LEN[k]}) begin
                    if (fcr_pkg::KW_PREFIX[k]) begin
                        parse_en = step.take;
                    end else begin
                        alive_next[k] = 1'b0;
                    end
                end else if (fcr_pkg::kw_char(k, pos_reg) != upper) begin
                    alive_next[k] = 1'b0;
                end
            end
        end
        if (pos_reg != 8'hFF) begin
            pos_next = pos_reg + 8'd1;
        end
        if (step.restart) begin
            alive_next = '1;
            pos_next   = 8'd0;
        end else if (!step.take) begin
            alive_next = alive_reg;
            pos_next   = pos_reg;
        end
    end

    // First live keyword whose length fits the message wins.
    always_comb begin
        command = fcr_pkg::CMD_UNKNOWN;
        for (int k = fcr_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (alive_reg[k] &&
                (fcr_pkg::KW_PREFIX[k] ? (pos_reg >= {3'b000, fcr_pkg::KW_LEN[k]})
                                       : (pos_reg == {3'b000, fcr_pkg::KW_LEN[k]}))) begin
                command = fcr_pkg::cmd_t'(3'(k + 1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= '1;
            pos_reg   <= 8'd0;
        end else begin
            alive_reg <= alive_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fcr_number_parse.sv =====
// Decimal number reader for the text after a prefix keyword.
`default_nettype none

module fcr_number_parse (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire fcr_pkg::fcr_step_t step,
    input  wire logic               parse_en,
    output logic [15:0]             value
);

    fcr_pkg::num_phase_t phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic [15:0]         acc_reg, acc_next;
    logic                is_digit, is_space;
    logic [15:0]         acc_digit;

    assign is_digit  = step.data >= fcr_pkg::CHAR_ZERO && step.data <= fcr_pkg::CHAR_NINE;
    assign is_space  = step.data == fcr_pkg::CHAR_SPACE ||
                       (step.data >= fcr_pkg::CHAR_TAB && step.data <= fcr_pkg::CHAR_CR);
    assign acc_digit = (acc_reg << 3) + (acc_reg << 1) + {8'h00, step.data - fcr_pkg::CHAR_ZERO};
    assign value     = neg_reg ? 16'd0 - acc_reg : acc_reg;

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (step.restart) begin
            phase_next = fcr_pkg::NUM_SKIP;
            neg_next   = 1'b0;
            acc_next   = 16'd0;
        end else if (parse_en && phase_reg != fcr_pkg::NUM_DONE) begin
            if (phase_reg == fcr_pkg::NUM_SKIP && is_space) begin
                phase_next = fcr_pkg::NUM_SKIP;
            end else if (phase_reg == fcr_pkg::NUM_SKIP && step.data == fcr_pkg::CHAR_PLUS) begin
                phase_next = fcr_pkg::NUM_DIGITS;
            end else if (phase_reg == fcr_pkg::NUM_SKIP && step.data == fcr_pkg::CHAR_MINUS) begin
                phase_next = fcr_pkg::NUM_DIGITS;
                neg_next   = 1'b1;
            end else if (is_digit) begin
                phase_next = fcr_pkg::NUM_DIGITS;
                acc_next   = acc_digit;
            end else begin
                phase_next = fcr_pkg::NUM_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= fcr_pkg::NUM_SKIP;
            neg_reg   <= 1'b0;
            acc_reg   <= 16'd0;
        end else begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/framed_command_recognizer_unit.sv =====
// Top level of the framed command recogniser: input register, message control, result register.
//
//  Channel   Direction  Ports                                   Transfer when
//  s_        in         s_valid, s_ready, s_rx_byte             s_valid && s_ready
//  m_        out        m_valid, m_ready, m_command, m_number   m_valid && m_ready
//  cfg_      in         cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid && cfg_ready
//
// Each byte is held in the input register until it moves on; a byte that closes a message
// loads the result register as it moves on, and its result is transferred from there.
// One byte per cycle is sustained while no result is stalled, as the next keyword mask and
// decimal accumulator are formed directly from the registered byte.
// Reset (aresetn low, synchronous) empties both registers and restores hash and percent.
// A stalled result keeps the next byte waiting; after at most one further transfer s_ready falls.
`default_nettype none

module framed_command_recognizer_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_rx_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [2:0]                             m_command,
    output logic signed [15:0]                     m_number,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fcr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [7:0]                        cfg_data
);

    logic               in_valid_reg;
    logic [7:0]         in_data_reg;
    logic [7:0]         start_char_reg;
    logic [7:0]         end_char_reg;
    logic               in_message_reg, in_message_next;
    logic               out_valid_reg;
    logic [2:0]         out_command_reg;
    logic [15:0]        out_number_reg;

    logic               advance;
    logic               is_start, is_end, emit;
    logic               parse_en;
    fcr_pkg::fcr_step_t step;
    fcr_pkg::cmd_t      command;
    logic [15:0]        value;
    logic [15:0]        number_sel;

    // The registered byte moves on whenever the result register is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign is_start = in_data_reg == start_char_reg;
    assign is_end   = in_data_reg == end_char_reg;

    // The start test comes first, then the end test, and only then the newline drop.
    assign step.restart = advance && is_start;
    assign step.take    = advance && !is_start && in_message_reg && !is_end &&
                          in_data_reg != fcr_pkg::CHAR_NEWLINE;
    assign step.data    = in_data_reg;
    assign emit         = advance && !is_start && in_message_reg && is_end;

    always_comb begin
        in_message_next = in_message_reg;
        if (step.restart) begin
            in_message_next = 1'b1;
        end else if (emit) begin
            in_message_next = 1'b0;
        end
    end

    // Only the numbered commands carry a value; the mode switch keeps its low byte.
    always_comb begin
        case (command)
            fcr_pkg::CMD_BYTE_VALUE: number_sel = value;
            fcr_pkg::CMD_MODE:       number_sel = {8'h00, value[7:0]};
            default:                 number_sel = 16'd0;
        endcase
    end

    fcr_keyword_match u_keyword (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .parse_en (parse_en),
        .command  (command)
    );

    fcr_number_parse u_number (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .parse_en (parse_en),
        .value    (value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            in_message_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            start_char_reg <= fcr_pkg::START_CHAR_RESET;
            end_char_reg   <= fcr_pkg::END_CHAR_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            in_message_reg <= in_message_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == fcr_pkg::CFG_START_CHAR) begin
                    start_char_reg <= cfg_data;
                end else if (cfg_index == fcr_pkg::CFG_END_CHAR) begin
                    end_char_reg <= cfg_data;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_rx_byte;
        end
        if (emit) begin
            out_command_reg <= command;
            out_number_reg  <= number_sel;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_command = out_command_reg;
    assign m_number  = out_number_reg;

endmodule

`default_nettype wire

// ===== rtl/fcr_checker.sv =====
// Port-level assertions for the framed command recogniser and their binding.
`default_nettype none

module fcr_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_ready,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic [2:0]                        m_command,
    input  wire logic signed [15:0]                m_number,
    input  wire logic                              cfg_ready
);

    // No result is offered straight after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // A stalled result holds still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_command) && $stable(m_number))
        else $error("stalled result changed");

    // Commands without a number report zero.
    a_zero_number: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_command != fcr_pkg::CMD_BYTE_VALUE &&
        m_command != fcr_pkg::CMD_MODE |-> m_number == 16'sd0)
        else $error("number on a command that carries none");

    // The mode switch carries only a byte.
    a_mode_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_command == fcr_pkg::CMD_MODE |-> m_number[15:8] == 8'h00)
        else $error("mode value wider than a byte");

    // With no result waiting, both input channels are open.
    a_input_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready && cfg_ready)
        else $error("input refused with the result register empty");

endmodule

bind framed_command_recognizer_unit fcr_checker u_fcr_checker (.*);

`default_nettype wire
